// File: design/krt_pkg.sv
// Shared types, sizes and codes for the keyed record table.
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_CHARS  = 25;

  localparam int KEY_W    = 31;
  localparam int WORD_W   = 64;
  localparam int LAST_W   = 8;
  localparam int NAME_W   = 3 * WORD_W + LAST_W;
  localparam int CNT_W    = 32;
  localparam int DATA_W   = 264;
  localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W   = $clog2(TABLE_DEPTH + 1);

  // keep only the first NAME_CHARS characters
  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_CHARS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [NAME_W-1:0]       name;
    logic signed [CNT_W-1:0] count;
  } rec_t;

endpackage

// File: design/krt_cell.sv
// One record cell of the rotating table; loads its neighbor's record on shift.
module krt_cell
  import krt_pkg::*;
(
  input  logic clk,
  input  logic shift,
  input  rec_t d,
  output rec_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: design/keyed_record_table.sv
// Keyed record table: top level with the cell ring and the operation sequencer.
// Insert into a full table and list of an empty table answer straight from idle.
// Other operations rotate the ring of TABLE_DEPTH cells once and answer from the
// response state after it; list streams one result per filled record instead.
// Requests do not overlap: one is taken only in idle with no result pending;
// output backpressure stalls the rotation during list.
// Reset clears control state and fill level; record cells are not reset.
module keyed_record_table
  import krt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // part_key, name_word0..3, quantity, zero pad
  input  logic [1:0]        s_tuser,  // action
  // result channel
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,  // found_key, out_name0..3, count_on_hand, zero pad
  output logic [1:0]        m_tuser,  // status
  output logic              m_tlast   // last
);

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_RUN  = 3'b010,
    FSM_RESP = 3'b100
  } fsm_t;

  fsm_t              state;
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  step;
  logic              found;
  action_t           req_act;
  rec_t              req_rec;   // key, masked name and quantity of the request
  rec_t              cap;       // record reported at the end of the rotation

  logic              out_valid;
  status_t           out_status;
  rec_t              out_rec;
  logic              out_last;

  // the ring: cell i takes from cell i+1, the last cell takes the wrap record
  rec_t ring_q [TABLE_DEPTH];
  rec_t ring_d [TABLE_DEPTH];
  rec_t head, wrap, head_upd, new_rec;
  logic shift;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == TABLE_DEPTH - 1) begin : g_tail
        assign ring_d[g] = wrap;
      end else begin : g_mid
        assign ring_d[g] = ring_q[g+1];
      end
      krt_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (ring_d[g]),
        .q     (ring_q[g])
      );
    end
  endgenerate

  assign head = ring_q[0];

  // request decode
  always_comb begin
    new_rec.key   = s_tdata[KEY_W-1:0];
    new_rec.name  = s_tdata[KEY_W+NAME_W-1:KEY_W] & NAME_MASK;
    new_rec.count = s_tdata[KEY_W+NAME_W+CNT_W-1:KEY_W+NAME_W];
  end

  // saturating count update on the head record
  logic [CNT_W:0] sum;
  always_comb begin
    sum      = {head.count[CNT_W-1], head.count} + {req_rec.count[CNT_W-1], req_rec.count};
    head_upd = head;
    if (sum[CNT_W] != sum[CNT_W-1]) begin
      head_upd.count = sum[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
    end else begin
      head_upd.count = sum[CNT_W-1:0];
    end
  end

  logic in_range, match, ins_here, emit, last_step, is_list;
  always_comb begin
    is_list   = (req_act == ACT_LIST);
    in_range  = FILL_W'(step) < fill;
    match     = in_range && !is_list && !found && (head.key == req_rec.key);
    ins_here  = (req_act == ACT_INSERT) && !found && (FILL_W'(step) == fill);
    emit      = is_list && in_range;
    last_step = (step == IDX_W'(TABLE_DEPTH - 1));
    // list stalls only while the output slot is held
    shift     = (state == FSM_RUN) && !(emit && out_valid && !m_tready);
    wrap      = head;
    if (ins_here) begin
      wrap = req_rec;
    end else if (match && req_act == ACT_UPDATE) begin
      wrap = head_upd;
    end
  end

  assign s_tready = (state == FSM_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      fill      <= '0;
      step      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a list result loaded this cycle keeps the slot full
      if (out_valid && m_tready && !(shift && emit)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        FSM_IDLE: begin
          if (s_tvalid && s_tready) begin
            req_act <= action_t'(s_tuser);
            req_rec <= new_rec;
            step    <= '0;
            found   <= 1'b0;
            if (action_t'(s_tuser) == ACT_INSERT && fill == FILL_W'(TABLE_DEPTH)) begin
              // table full: answered at once, key echoed
              out_valid       <= 1'b1;
              out_status      <= ST_FULL;
              out_rec         <= '{key: new_rec.key, name: '0, count: '0};
              out_last        <= 1'b1;
            end else if (action_t'(s_tuser) == ACT_LIST && fill == '0) begin
              out_valid  <= 1'b1;
              out_status <= ST_NOT_FOUND;
              out_rec    <= '0;
              out_last   <= 1'b1;
            end else begin
              state <= FSM_RUN;
            end
          end
        end
        FSM_RUN: begin
          if (shift) begin
            step <= step + IDX_W'(1);
            if (match) begin
              found <= 1'b1;
              cap   <= wrap;
            end
            if (ins_here) begin
              cap <= req_rec;
            end
            if (emit) begin
              out_valid  <= 1'b1;
              out_status <= ST_OK;
              out_rec    <= head;
              out_last   <= (FILL_W'(step) == fill - FILL_W'(1));
            end
            if (last_step) begin
              if (req_act == ACT_INSERT && !found && !match) begin
                fill <= fill + FILL_W'(1);
              end
              state <= is_list ? FSM_IDLE : FSM_RESP;
            end
          end
        end
        FSM_RESP: begin
          // output slot is empty here: nothing was emitted during the rotation
          out_valid <= 1'b1;
          out_last  <= 1'b1;
          if (req_act == ACT_INSERT) begin
            out_status <= found ? ST_EXISTS : ST_OK;
            out_rec    <= cap;
          end else if (found) begin
            out_status <= ST_OK;
            out_rec    <= cap;
          end else begin
            out_status  <= ST_NOT_FOUND;
            out_rec     <= '{key: req_rec.key, name: '0, count: '0};
          end
          state <= FSM_IDLE;
        end
        default: begin
          state <= FSM_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(DATA_W - KEY_W - NAME_W - CNT_W){1'b0}},
                     out_rec.count, out_rec.name, out_rec.key};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

// File: design/krt_checker.sv
// Port-level checks for the keyed record table, bound to the top level.
module krt_checker
  import krt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [1:0]        m_tuser,
  input logic              m_tlast
);

  // held result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result dropped or changed while stalled");

  // a new request is never taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request accepted with result pending");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after a request");

  // duplicate and full answers are single results
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EXISTS || m_tuser == ST_FULL) |-> m_tlast)
    else $error("single-result status without last");

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);

// File: tb/keyed_record_table_tb.sv
// Self-checking testbench for keyed_record_table: directed, random and stall tests.
`timescale 1ns / 100ps

module keyed_record_table_tb;
  import krt_pkg::*;

  localparam int  CLK_PERIOD  = 4;
  localparam int  RESET_CYC   = 3;
  localparam int  RANDOM_REQS = 40;
  localparam int  BURST_REQS  = 16;
  localparam int  STALL_CYC   = 400;
  localparam int  MAX_REPORTS = 10;
  // the watchdog allows several times the slowest legal run
  localparam time WATCHDOG_NS = 64'd2_400_000;

  // one result as seen on the master side
  typedef struct packed {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic [NAME_W-1:0]       name;
    logic signed [CNT_W-1:0] count;
    logic                    last;
  } reply_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic [1:0]        s_tuser  = ACT_SEARCH;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;

  keyed_record_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the table contents
  logic [KEY_W-1:0]        shadow_key   [TABLE_DEPTH];
  logic [NAME_W-1:0]       shadow_name  [TABLE_DEPTH];
  logic signed [CNT_W-1:0] shadow_count [TABLE_DEPTH];
  int                      shadow_fill = 0;

  reply_t awaited_replies[$];

  bit idle_en   = 1'b1;  // random idle bursts on both sides
  int hold_req  = 0;     // long receiver hold-off, in cycles
  int fail_count    = 0;
  int reports       = 0;
  int req_count     = 0;
  int reply_count   = 0;
  int list_count    = 0;
  int full_rejects  = 0;
  int saturations   = 0;

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // linear search over filled entries, first match wins
  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_fill; i++)
      if (shadow_key[i] == key) return i;
    return -1;
  endfunction

  // idx < 0 reports an absent record: key echoed, name and count zero
  function automatic void push_reply(status_t st, int idx, logic [KEY_W-1:0] key, bit last);
    reply_t r;
    r.status = st;
    r.last   = last;
    if (idx >= 0) begin
      r.key   = shadow_key[idx];
      r.name  = shadow_name[idx];
      r.count = shadow_count[idx];
    end else begin
      r.key   = key;
      r.name  = '0;
      r.count = '0;
    end
    awaited_replies.push_back(r);
  endfunction

  function automatic void predict_request(action_t act, logic [KEY_W-1:0] key,
                                          logic [NAME_W-1:0] name,
                                          logic signed [CNT_W-1:0] qty);
    int            idx;
    logic [CNT_W:0] sum;
    idx = find_entry(key);
    case (act)
      ACT_INSERT: begin
        // fullness is checked before the key
        if (shadow_fill >= TABLE_DEPTH) begin
          push_reply(ST_FULL, -1, key, 1'b1);
          full_rejects++;
        end else if (idx >= 0) begin
          push_reply(ST_EXISTS, idx, key, 1'b1);
        end else begin
          shadow_key[shadow_fill]   = key;
          shadow_name[shadow_fill]  = name & NAME_MASK;
          shadow_count[shadow_fill] = qty;
          shadow_fill++;
          push_reply(ST_OK, shadow_fill - 1, key, 1'b1);
        end
      end
      ACT_SEARCH, ACT_UPDATE: begin
        if (idx < 0) begin
          push_reply(ST_NOT_FOUND, -1, key, 1'b1);
        end else begin
          if (act == ACT_UPDATE) begin
            sum = {shadow_count[idx][CNT_W-1], shadow_count[idx]} + {qty[CNT_W-1], qty};
            // top two bits disagree on signed overflow
            if (sum[CNT_W] != sum[CNT_W-1]) begin
              shadow_count[idx] = sum[CNT_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
              saturations++;
            end else begin
              shadow_count[idx] = sum[CNT_W-1:0];
            end
          end
          push_reply(ST_OK, idx, key, 1'b1);
        end
      end
      default: begin
        list_count++;
        if (shadow_fill == 0) push_reply(ST_NOT_FOUND, -1, '0, 1'b1);
        else
          for (int i = 0; i < shadow_fill; i++)
            push_reply(ST_OK, i, '0, i == shadow_fill - 1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver; valid stays high on return so requests can go back to back
  // ---------------------------------------------------------------------------
  task automatic send_request(action_t act, logic [KEY_W-1:0] key,
                              logic [NAME_W-1:0] name, logic signed [CNT_W-1:0] qty);
    int gap;
    predict_request(act, key, name, qty);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, qty, name, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    req_count++;
  endtask

  // drop valid and wait until every awaited result has shown up
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random idle bursts, plus a long counted hold when requested
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.key    = m_tdata[KEY_W-1:0];
      got.name   = m_tdata[KEY_W +: NAME_W];
      got.count  = m_tdata[KEY_W + NAME_W +: CNT_W];
      got.last   = m_tlast;
      reply_count++;
      if (awaited_replies.size() == 0) begin
        fail_count++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected result st=%0d key=%h cnt=%0d last=%b",
                   $realtime, got.status, got.key, got.count, got.last);
        end
      end else begin
        want = awaited_replies.pop_front();
        if (got !== want) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: result mismatch", $realtime);
            $display("  status exp %0d got %0d | key exp %h got %h | last exp %b got %b",
                     want.status, got.status, want.key, got.key, want.last, got.last);
            $display("  count exp %0d got %0d", want.count, got.count);
            $display("  name exp %h", want.name);
            $display("  name got %h", got.name);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [NAME_W-1:0] rand_name();
    logic [223:0] wide;
    wide = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return wide[NAME_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {KEY_W{1'b1}};
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [CNT_W-1:0] rand_qty();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // mostly keys that hit the table, some misses and duplicate inserts
  task automatic send_random_request();
    int               pick;
    action_t          act;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 35)      act = ACT_INSERT;
    else if (pick < 60) act = ACT_SEARCH;
    else if (pick < 88) act = ACT_UPDATE;
    else                act = ACT_LIST;
    if (shadow_fill > 0 &&
        ((act == ACT_INSERT) ? ($urandom_range(0, 6) == 0) : ($urandom_range(0, 4) != 0)))
      key = shadow_key[$urandom_range(0, shadow_fill - 1)];
    else
      key = rand_key();
    send_request(act, key, rand_name(), rand_qty());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // list, search and update against an empty table
  task automatic test_empty_table();
    send_request(ACT_LIST, '0, '0, '0);
    send_request(ACT_SEARCH, 31'h1234_5678, '1, '1);
    send_request(ACT_UPDATE, {KEY_W{1'b1}}, '0, 32'sh7FFF_FFFF);
  endtask

  // extreme keys, names and counts
  task automatic test_insert_edges();
    send_request(ACT_INSERT, '0, '0, '0);
    send_request(ACT_INSERT, {KEY_W{1'b1}}, '1, 32'sh7FFF_FFFF);
    send_request(ACT_INSERT, 31'h2AAA_AAAA, {25{8'hA5}}, 32'sh8000_0000);
    send_request(ACT_INSERT, 31'h5555_5555, {25{8'h5A}}, -32'sd1);
  endtask

  // duplicate keys report the existing record untouched
  task automatic test_duplicates();
    send_request(ACT_INSERT, '0, '1, 32'sd99);
    send_request(ACT_INSERT, {KEY_W{1'b1}}, '0, '0);
  endtask

  task automatic test_lookup_and_update();
    send_request(ACT_SEARCH, {KEY_W{1'b1}}, '0, '0);
    send_request(ACT_SEARCH, 31'h0000_0001, '0, '0);
    send_request(ACT_UPDATE, '0, '1, 32'sd5);
    send_request(ACT_UPDATE, 31'h7FFF_FFFE, '0, 32'sd1);
    send_request(ACT_LIST, '0, '0, '0);
  endtask

  // count clamps at both signed limits
  task automatic test_count_saturation();
    send_request(ACT_UPDATE, {KEY_W{1'b1}}, '0, 32'sd1);
    send_request(ACT_UPDATE, 31'h2AAA_AAAA, '0, -32'sd1);
    send_request(ACT_UPDATE, {KEY_W{1'b1}}, '0, 32'sh8000_0000);
    send_request(ACT_UPDATE, 31'h5555_5555, '0, 32'sh8000_0000);
  endtask

  task automatic test_random_mix();
    repeat (RANDOM_REQS) send_random_request();
  endtask

  // fill every slot, then confirm full rejects even for a known key
  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] key;
    while (shadow_fill < TABLE_DEPTH) begin
      key = KEY_W'($urandom);
      while (find_entry(key) >= 0) key = KEY_W'($urandom);
      send_request(ACT_INSERT, key, rand_name(), rand_qty());
    end
    key = KEY_W'($urandom);
    while (find_entry(key) >= 0) key = KEY_W'($urandom);
    send_request(ACT_INSERT, key, rand_name(), rand_qty());
    send_request(ACT_INSERT, shadow_key[0], rand_name(), rand_qty());
    send_request(ACT_SEARCH, shadow_key[TABLE_DEPTH-1], '0, '0);
    send_request(ACT_UPDATE, shadow_key[TABLE_DEPTH-1], '0, rand_qty());
    send_request(ACT_LIST, '0, '0, '0);
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_stall();
    drain_replies();
    hold_req = STALL_CYC;
    send_request(ACT_LIST, '0, '0, '0);
    repeat (5) send_random_request();
    send_request(ACT_LIST, '0, '0, '0);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_closing_burst();
    drain_replies();
    idle_en = 1'b0;
    repeat (BURST_REQS) send_random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_insert_edges();
    test_duplicates();
    test_lookup_and_update();
    test_count_saturation();
    test_random_mix();
    test_fill_to_capacity();
    test_output_stall();
    test_closing_burst();

    drain_replies();
    // a stray extra result would show up during this wait
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);

    $display("Covered %0d requests (%0d lists, %0d full rejects, %0d clamped updates),",
             req_count, list_count, full_rejects, saturations);
    $display("%0d results checked, %0d records stored, %0d failures.",
             reply_count, shadow_fill, fail_count);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Timed out with %0d results still awaited.", awaited_replies.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
